@@ src/hrsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request stream parser package
// Shared types and character constants for the request parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

   typedef enum logic [1:0] {
      PH_REQ  = 2'd0,
      PH_HDR  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_CONT = 2'd0,
      ST_DONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam int         NAME_LEN = 15;

   // Lowercase letter of the method GET at a token index.
   function automatic logic [7:0] get_char(input logic [7:0] idx);
      case (idx)
         8'd0:    get_char = "g";
         8'd1:    get_char = "e";
         8'd2:    get_char = "t";
         default: get_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] post_char(input logic [7:0] idx);
      case (idx)
         8'd0:    post_char = "p";
         8'd1:    post_char = "o";
         8'd2:    post_char = "s";
         8'd3:    post_char = "t";
         default: post_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] vera_char(input logic [7:0] idx);
      case (idx)
         8'd0:    vera_char = "h";
         8'd1:    vera_char = "t";
         8'd2:    vera_char = "t";
         8'd3:    vera_char = "p";
         8'd4:    vera_char = "/";
         8'd5:    vera_char = "1";
         8'd6:    vera_char = ".";
         8'd7:    vera_char = "1";
         default: vera_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] verb_char(input logic [7:0] idx);
      case (idx)
         8'd0:    verb_char = "h";
         8'd1:    verb_char = "t";
         8'd2:    verb_char = "t";
         8'd3:    verb_char = "p";
         8'd4:    verb_char = "1";
         8'd5:    verb_char = ".";
         8'd6:    verb_char = "1";
         default: verb_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] clen_char(input logic [7:0] idx);
      case (idx)
         8'd0:    clen_char = "c";
         8'd1:    clen_char = "o";
         8'd2:    clen_char = "n";
         8'd3:    clen_char = "t";
         8'd4:    clen_char = "e";
         8'd5:    clen_char = "n";
         8'd6:    clen_char = "t";
         8'd7:    clen_char = "-";
         8'd8:    clen_char = "l";
         8'd9:    clen_char = "e";
         8'd10:   clen_char = "n";
         8'd11:   clen_char = "g";
         8'd12:   clen_char = "t";
         8'd13:   clen_char = "h";
         8'd14:   clen_char = ":";
         default: clen_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

endpackage

`default_nettype wire

@@ src/http_request_stream_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request stream parser
// Parses an HTTP/1.1 request one byte per item and reports status, URL span
// and content length for every byte.
// ----------------------------------------------------------------------------
// The block takes one request byte per clock and returns one result item per
// byte in the next cycle via a result register. All parsing for a byte is
// a single pass of logic between the parser state and the result register,
// so sustained throughput is one item per cycle; the result register and the
// stall on the result side are the only things that can hold the input back.
// While a result waits under stall, the input is stalled until that result
// is taken. The value accumulator adds one decimal digit per unstalled cycle.
module http_request_stream_parser_unit
   import hrsp_pkg::*;
#(
   parameter int MAX_LINE    = 4096,
   parameter int LENGTH_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_is_post,
   output      logic [11:0] rsp_url_start,
   output      logic [11:0] rsp_url_end,
   output      logic [31:0] rsp_content_length,
   output      logic        rsp_body_byte
);

   localparam int POS_BITS = $clog2(MAX_LINE + 1);
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN_TEN = LENGTH_BITS'(10);
   localparam logic [LENGTH_BITS-1:0] SAT_LIMIT = LEN_MAX / LEN_TEN;
   localparam logic [3:0] SAT_DIGIT = 4'(LEN_MAX % LEN_TEN);

   // Parser state.
   phase_type              phase_ff, phase_in;
   logic [2:0]             field_ff, field_in;
   logic                   after_cr_ff, after_cr_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [7:0]             match_ff, match_in;
   logic [7:0]             idx_ff, idx_in;
   logic                   fault_ff, fault_in;
   logic                   post_ff, post_in;
   logic [11:0]            ufirst_ff, ufirst_in;
   logic [11:0]            ulast_ff, ulast_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LENGTH_BITS-1:0] body_ff, body_in;

   // Result register.
   logic                   rv_ff;
   logic [1:0]             rstat_ff;
   logic                   rpost_ff, rbody_ff;
   logic [11:0]            rus_ff, rue_ff;
   logic [31:0]            rlen_ff;

   logic                   take;
   status_type             status;
   logic                   body_flag;
   logic [7:0]             c, lc;
   logic                   blank, digit;
   logic [3:0]             dval;
   logic [LENGTH_BITS-1:0] digit_sum;
   logic [LENGTH_BITS-1:0] body_next;
   logic [7:0]             idx_inc;

   assign req_stall = rv_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign c         = req_data_byte;
   assign lc        = to_lower(c);
   assign blank     = (c == CH_SP) || (c == CH_TAB);
   assign digit     = (c >= "0") && (c <= "9");
   assign dval      = c[3:0];
   assign idx_inc   = (idx_ff < 8'd255) ? idx_ff + 8'd1 : idx_ff;
   assign body_next = body_ff + LENGTH_BITS'(1);
   // One decimal digit: saturate when value*10+d would overflow.
   assign digit_sum = ((len_ff > SAT_LIMIT) || (len_ff == SAT_LIMIT && dval > SAT_DIGIT))
                      ? LEN_MAX : (len_ff << 3) + (len_ff << 1) + LENGTH_BITS'(dval);

   // Next state for one byte.
   always_comb begin
      phase_in  = phase_ff;
      field_in  = field_ff;
      after_cr_in = after_cr_ff;
      pos_in    = pos_ff;
      match_in  = match_ff;
      idx_in    = idx_ff;
      fault_in  = fault_ff;
      post_in   = post_ff;
      ufirst_in = ufirst_ff;
      ulast_in  = ulast_ff;
      len_in    = len_ff;
      body_in   = body_ff;
      status    = ST_CONT;
      body_flag = 1'b0;
      if (phase_ff == PH_BODY) begin
         body_flag = 1'b1;
         body_in   = body_next;
         if (body_next >= len_ff) status = ST_DONE;
      end else if (after_cr_ff) begin
         if (c != CH_LF) begin
            status = ST_BAD;
         end else begin
            after_cr_in = 1'b0;
            if (phase_ff == PH_REQ) begin
               if (fault_ff || field_ff != 3'd4 ||
                   !((!match_ff[0] && idx_ff == 8'd8) || (!match_ff[1] && idx_ff == 8'd7)))
                  status = ST_BAD;
               else
                  phase_in = PH_HDR;
            end else if (pos_ff == '0) begin
               if (!post_ff || len_ff == '0) status = ST_DONE;
               else begin
                  phase_in = PH_BODY;
                  body_in  = '0;
               end
            end
            field_in = 3'd0;
            pos_in   = '0;
            match_in = '0;
            idx_in   = '0;
         end
      end else if (c == CH_CR) begin
         after_cr_in = 1'b1;
      end else if (c == CH_LF) begin
         status = ST_BAD;
      end else if (pos_ff >= POS_BITS'(MAX_LINE)) begin
         status = ST_BAD;
      end else begin
         pos_in = pos_ff + POS_BITS'(1);
         if (phase_ff == PH_REQ) begin
            case (field_ff)
               3'd0: begin
                  if (blank) begin
                     if (!match_ff[0] && idx_ff == 8'd3) post_in = 1'b0;
                     else if (!match_ff[1] && idx_ff == 8'd4) post_in = 1'b1;
                     else fault_in = 1'b1;
                     field_in = 3'd1;
                  end else begin
                     if (idx_ff >= 8'd3 || lc != get_char(idx_ff)) match_in[0] = 1'b1;
                     if (idx_ff >= 8'd4 || lc != post_char(idx_ff)) match_in[1] = 1'b1;
                     idx_in = idx_inc;
                  end
               end
               3'd1, 3'd2: begin
                  if (blank) begin
                     if (field_ff == 3'd2) begin
                        if (!match_ff[7]) fault_in = 1'b1;
                        ulast_in = 12'(pos_ff);
                        field_in = 3'd3;
                     end
                  end else begin
                     field_in = 3'd2;
                     if (c == CH_SLASH) begin
                        ufirst_in   = 12'(pos_ff);
                        match_in[7] = 1'b1;
                     end
                  end
               end
               3'd3: begin
                  if (!blank) begin
                     field_in = 3'd4;
                     match_in = '0;
                     match_in[0] = (lc != vera_char(8'd0));
                     match_in[1] = (lc != verb_char(8'd0));
                     idx_in = 8'd1;
                  end
               end
               default: begin
                  if (idx_ff >= 8'd8 || lc != vera_char(idx_ff)) match_in[0] = 1'b1;
                  if (idx_ff >= 8'd7 || lc != verb_char(idx_ff)) match_in[1] = 1'b1;
                  idx_in = idx_inc;
               end
            endcase
         end else begin
            case (field_ff)
               3'd0: begin
                  if (idx_ff < 8'(NAME_LEN) && lc == clen_char(idx_ff)) begin
                     idx_in = idx_ff + 8'd1;
                     if (idx_ff == 8'(NAME_LEN - 1)) begin
                        field_in = 3'd1;
                        len_in   = '0;
                     end
                  end else begin
                     field_in = 3'd3;
                  end
               end
               3'd1: begin
                  if (!(blank || c == CH_VT || c == CH_FF)) begin
                     if (c == CH_PLUS) field_in = 3'd2;
                     else if (digit) begin
                        len_in   = digit_sum;
                        field_in = 3'd2;
                     end else field_in = 3'd3;
                  end
               end
               3'd2: begin
                  if (digit) len_in = digit_sum;
                  else field_in = 3'd3;
               end
               default: ;
            endcase
         end
      end
      // Complete or bad returns the parser to its reset state.
      if (status != ST_CONT) begin
         phase_in = PH_REQ; field_in = '0; after_cr_in = 1'b0; pos_in = '0;
         match_in = '0; idx_in = '0; fault_in = 1'b0; post_in = 1'b0;
         ufirst_in = '0; ulast_in = '0; len_in = '0; body_in = '0;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_REQ; field_ff <= '0; after_cr_ff <= 1'b0; pos_ff <= '0;
         match_ff <= '0; idx_ff <= '0; fault_ff <= 1'b0; post_ff <= 1'b0;
         ufirst_ff <= '0; ulast_ff <= '0; len_ff <= '0; body_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; field_ff <= field_in; after_cr_ff <= after_cr_in;
         pos_ff <= pos_in; match_ff <= match_in; idx_ff <= idx_in;
         fault_ff <= fault_in; post_ff <= post_in; ufirst_ff <= ufirst_in;
         ulast_ff <= ulast_in; len_ff <= len_in; body_ff <= body_in;
      end
   end

   // Result register; fields show the state before any reset this byte causes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (take) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rstat_ff <= status;
         rbody_ff <= body_flag;
         rpost_ff <= (status != ST_CONT) ? post_ff : post_in;
         rus_ff   <= (status != ST_CONT) ? ufirst_ff : ufirst_in;
         rue_ff   <= (status != ST_CONT) ? ulast_ff : ulast_in;
         if (status != ST_CONT) begin
            rlen_ff  <= (LENGTH_BITS > 32 && (len_ff >> 32) != '0) ? 32'hffff_ffff : 32'(len_ff);
         end else begin
            rlen_ff  <= (LENGTH_BITS > 32 && (len_in >> 32) != '0) ? 32'hffff_ffff : 32'(len_in);
         end
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = rstat_ff;
   assign rsp_is_post        = rpost_ff;
   assign rsp_url_start      = rus_ff;
   assign rsp_url_end        = rue_ff;
   assign rsp_content_length = rlen_ff;
   assign rsp_body_byte      = rbody_ff;

   // Checks on parser behavior.
   a_body_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_byte |-> rsp_status != ST_BAD)
      else $error("body byte reported as bad");
   a_body_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> post_ff && !after_cr_ff)
      else $error("body phase without POST");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result lost");

endmodule

`default_nettype wire
